>>> rtl/sdda_pkg.sv
// ----------------------------------------------------------------------------
// sdda_pkg
// shared command codes and queue depth for the symmetric dda line stepper
// ----------------------------------------------------------------------------
package sdda_pkg;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [1:0] queue_count_t;

endpackage

>>> rtl/symmetric_dda_line_stepper_top.sv
// ----------------------------------------------------------------------------
// symmetric_dda_line_stepper_top
// symmetric dda line rasterizer, one point per advance word
// ----------------------------------------------------------------------------
// A start word (action 0) latches both endpoints and gives no point; equal
// endpoints leave no line active. Each advance word (action 1) then emits the
// next of the 2^n points of the line, n being the bit length of the larger
// delta, rounded half away from zero, with last_point set on the endpoint; an
// advance with no line active gives nothing. The block takes one word per
// clock while the queue is not full: the front classifies each word in the
// cycle it arrives, a two-entry queue holds it, and the back does one
// accumulator step per cycle unless stalled, then rounding and output stages.
// ----------------------------------------------------------------------------
module symmetric_dda_line_stepper_top #(
    parameter int COORD_BITS = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         last_point
);
    import sdda_pkg::*;

    localparam int NW = $clog2(COORD_BITS + 1);
    localparam int DW = 4 * COORD_BITS + NW + 4;

    logic [DW-1:0] front_cmd;
    logic [DW-1:0] queue_cmd;
    logic          q_empty;
    logic          q_full;
    logic          push;
    logic          pop;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    sdda_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .action  (action),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .cmd     (front_cmd)
    );

    sdda_fifo #(
        .WIDTH (DW)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cmd),
        .pop     (pop),
        .rd_data (queue_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    sdda_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (queue_cmd),
        .cmd_valid  (!q_empty),
        .cmd_pop    (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_empty)
        else $error("queue empty right after a push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("back popped an empty queue");

    a_full_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_full) |-> $past(push))
        else $error("queue filled without a push");

endmodule

>>> rtl/sdda_front.sv
// ----------------------------------------------------------------------------
// sdda_front
// classifies an incoming word: deltas, line length exponent and empty line
// ----------------------------------------------------------------------------
module sdda_front #(
    parameter int COORD_BITS = 11,
    localparam int NW = $clog2(COORD_BITS + 1),
    localparam int DW = 4 * COORD_BITS + NW + 4
) (
    input  logic                         action,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic [DW-1:0]                cmd
);
    import sdda_pkg::*;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS-1:0]      adx;
    logic [COORD_BITS-1:0]      ady;
    logic [COORD_BITS-1:0]      m;
    logic [NW-1:0]              n;
    logic                       nonzero;

    always_comb
    begin
        dx  = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
        dy  = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
        adx = dx[COORD_BITS] ? (~dx[COORD_BITS-1:0] + 1'b1) : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? (~dy[COORD_BITS-1:0] + 1'b1) : dy[COORD_BITS-1:0];
        m   = (adx > ady) ? adx : ady;
        n   = '0;
        // bit length of the larger delta
        for (int i = 0; i < COORD_BITS; i++)
        begin
            if (m[i])
            begin
                n = NW'(i + 1);
            end
        end
        nonzero = |m;
        cmd = {action, nonzero, n, start_x, start_y, dx, dy};
    end

endmodule

>>> rtl/sdda_fifo.sv
// ----------------------------------------------------------------------------
// sdda_fifo
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module sdda_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);
    import sdda_pkg::*;

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    queue_count_t     count_reg;
    queue_count_t     count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == queue_count_t'(QUEUE_DEPTH));
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/sdda_back.sv
// ----------------------------------------------------------------------------
// sdda_back
// walks the active line: accumulator step, rounding stage, output register
// ----------------------------------------------------------------------------
module sdda_back #(
    parameter int COORD_BITS = 11,
    localparam int NW = $clog2(COORD_BITS + 1),
    localparam int DW = 4 * COORD_BITS + NW + 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [DW-1:0]                cmd,
    input  logic                         cmd_valid,
    output logic                         cmd_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         last_point
);
    import sdda_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int AW = 2 * COORD_BITS + 1;
    localparam int SW = COORD_BITS + 1;

    // command fields
    logic                  c_kind;
    logic                  c_nonzero;
    logic [NW-1:0]         c_shift;
    logic [C-1:0]          c_sx;
    logic [C-1:0]          c_sy;
    logic [C:0]            c_dx;
    logic [C:0]            c_dy;

    // line state
    logic                  active_reg;
    logic                  active_next;
    logic signed [AW-1:0]  acc_x_reg;
    logic signed [AW-1:0]  acc_x_next;
    logic signed [AW-1:0]  acc_y_reg;
    logic signed [AW-1:0]  acc_y_next;
    logic signed [AW-1:0]  dx_reg;
    logic signed [AW-1:0]  dx_next;
    logic signed [AW-1:0]  dy_reg;
    logic signed [AW-1:0]  dy_next;
    logic [NW-1:0]         shift_reg;
    logic [NW-1:0]         shift_next;
    logic [SW-1:0]         steps_reg;
    logic [SW-1:0]         steps_next;

    // rounding stage
    logic                  rnd_valid_reg;
    logic                  rnd_valid_next;
    logic signed [AW-1:0]  rnd_x_reg;
    logic signed [AW-1:0]  rnd_x_next;
    logic signed [AW-1:0]  rnd_y_reg;
    logic signed [AW-1:0]  rnd_y_next;
    logic [NW-1:0]         rnd_shift_reg;
    logic [NW-1:0]         rnd_shift_next;
    logic                  rnd_last_reg;
    logic                  rnd_last_next;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [C-1:0]          out_x_reg;
    logic [C-1:0]          out_x_next;
    logic [C-1:0]          out_y_reg;
    logic [C-1:0]          out_y_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic                  out_free;
    logic                  rnd_free;
    logic                  step;
    logic signed [AW-1:0]  half;
    logic signed [AW-1:0]  sum_x;
    logic signed [AW-1:0]  sum_y;
    logic signed [AW-1:0]  shr_x;
    logic signed [AW-1:0]  shr_y;

    assign c_dy      = cmd[C:0];
    assign c_dx      = cmd[2*C+1 -: C+1];
    assign c_sy      = cmd[3*C+1 -: C];
    assign c_sx      = cmd[4*C+1 -: C];
    assign c_shift   = cmd[4*C+NW+1 -: NW];
    assign c_nonzero = cmd[4*C+NW+2];
    assign c_kind    = cmd[4*C+NW+3];

    assign out_free = !out_valid_reg || out_ready;
    assign rnd_free = !rnd_valid_reg || out_free;
    assign cmd_pop  = cmd_valid && rnd_free;
    assign step     = cmd_pop && (c_kind == CMD_ADVANCE) && active_reg;

    assign out_valid  = out_valid_reg;
    assign point_x    = out_x_reg;
    assign point_y    = out_y_reg;
    assign last_point = out_last_reg;

    always_comb
    begin
        active_next = active_reg;
        acc_x_next  = acc_x_reg;
        acc_y_next  = acc_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        shift_next  = shift_reg;
        steps_next  = steps_reg;
        if (cmd_pop && (c_kind == CMD_START))
        begin
            active_next = c_nonzero;
            acc_x_next  = $signed({{(AW-C){c_sx[C-1]}}, c_sx}) <<< c_shift;
            acc_y_next  = $signed({{(AW-C){c_sy[C-1]}}, c_sy}) <<< c_shift;
            dx_next     = $signed({{(AW-C-1){c_dx[C]}}, c_dx});
            dy_next     = $signed({{(AW-C-1){c_dy[C]}}, c_dy});
            shift_next  = c_shift;
            steps_next  = SW'(1) << c_shift;
        end
        else if (step)
        begin
            acc_x_next = acc_x_reg + dx_reg;
            acc_y_next = acc_y_reg + dy_reg;
            steps_next = steps_reg - 1'b1;
            if (steps_reg == SW'(1))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        rnd_valid_next = rnd_valid_reg;
        rnd_x_next     = rnd_x_reg;
        rnd_y_next     = rnd_y_reg;
        rnd_shift_next = rnd_shift_reg;
        rnd_last_next  = rnd_last_reg;
        if (rnd_free)
        begin
            rnd_valid_next = step;
            rnd_x_next     = acc_x_reg + dx_reg;
            rnd_y_next     = acc_y_reg + dy_reg;
            rnd_shift_next = shift_reg;
            rnd_last_next  = (steps_reg == SW'(1));
        end
    end

    // round half away from zero: (a + half - sign) >>> n
    always_comb
    begin
        half  = $signed((AW'(1) << rnd_shift_reg) >> 1);
        sum_x = rnd_x_reg + half - $signed(AW'(rnd_x_reg[AW-1]));
        sum_y = rnd_y_reg + half - $signed(AW'(rnd_y_reg[AW-1]));
        shr_x = sum_x >>> rnd_shift_reg;
        shr_y = sum_y >>> rnd_shift_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = rnd_valid_reg;
            out_x_next     = shr_x[C-1:0];
            out_y_next     = shr_y[C-1:0];
            out_last_next  = rnd_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            steps_reg     <= '0;
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            steps_reg     <= steps_next;
            rnd_valid_reg <= rnd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_x_reg     <= acc_x_next;
        acc_y_reg     <= acc_y_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        shift_reg     <= shift_next;
        rnd_x_reg     <= rnd_x_next;
        rnd_y_reg     <= rnd_y_next;
        rnd_shift_reg <= rnd_shift_next;
        rnd_last_reg  <= rnd_last_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_last_reg  <= out_last_next;
    end

endmodule
